/* rtl/edsch_pkg.sv */
// Package for the elevator direction scheduler: widths, codes and the
// structs passed between the top level and the row of floor cells.
// No dependencies.
package edsch_pkg;

   localparam int FLOOR_W    = 6;
   localparam int MAX_FLOORS = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_FLOORS = 2'd0;
   localparam logic [FLOOR_W-1:0]    NUM_FLOORS_RESET = 6'd32;

   localparam logic REQ_FLOOR = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef struct packed {
      logic               set_up;
      logic               set_dn;
      logic               clr_up;
      logic               clr_dn;
      logic [FLOOR_W-1:0] floor;
   } cmd_type;

   // A floor of zero means that nothing has been found yet.
   typedef struct packed {
      logic [FLOOR_W-1:0] low_up;
      logic [FLOOR_W-1:0] high_dn;
   } scan_type;

endpackage

/* rtl/edsch_if.sv */
// Channel interfaces of the elevator direction scheduler.
// Depends on edsch_pkg for the floor width.
interface edsch_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [edsch_pkg::FLOOR_W-1:0] floor;
   logic                          request_up;

   modport source (output valid, output req_type, output floor, output request_up,
                   input ready);
   modport sink (input valid, input req_type, input floor, input request_up,
                 output ready);
endinterface

interface edsch_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [edsch_pkg::FLOOR_W-1:0] current_floor;
   logic                          direction_up;
   logic                          is_idle;
   logic                          moved;
   logic                          door_opened;
   logic                          request_rejected;

   modport source (output valid, output current_floor, output direction_up,
                   output is_idle, output moved, output door_opened,
                   output request_rejected, input ready);
   modport sink (input valid, input current_floor, input direction_up,
                 input is_idle, input moved, input door_opened,
                 input request_rejected, output ready);
endinterface

/* rtl/edsch_cell.sv */
// One floor cell: holds the up and down call bits of its floor and passes
// the lowest up call and highest down call seen so far to the next cell.
// Depends on edsch_pkg.
module edsch_cell #(
   parameter int CELL_FLOOR = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  edsch_pkg::cmd_type  cmd,
   input  edsch_pkg::scan_type scan_in,
   output edsch_pkg::scan_type scan_out
);

   localparam logic [edsch_pkg::FLOOR_W-1:0] MY_FLOOR = edsch_pkg::FLOOR_W'(CELL_FLOOR);

   logic                hit;
   logic                up_ff;
   logic                up_in;
   logic                dn_ff;
   logic                dn_in;
   edsch_pkg::scan_type scan_ff;
   edsch_pkg::scan_type scan_in_next;

   assign hit   = (cmd.floor == MY_FLOOR);
   assign up_in = (up_ff | (cmd.set_up & hit)) & ~(cmd.clr_up & hit);
   assign dn_in = (dn_ff | (cmd.set_dn & hit)) & ~(cmd.clr_dn & hit);

   always_comb begin
      scan_in_next.low_up  = ((scan_in.low_up == '0) && up_ff) ? MY_FLOOR : scan_in.low_up;
      scan_in_next.high_dn = dn_ff ? MY_FLOOR : scan_in.high_dn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff   <= 1'b0;
         dn_ff   <= 1'b0;
         scan_ff <= '0;
      end else begin
         up_ff   <= up_in;
         dn_ff   <= dn_in;
         scan_ff <= scan_in_next;
      end
   end

   assign scan_out = scan_ff;

endmodule

/* rtl/elevator_direction_scheduler_top.sv */
// Top level of the elevator direction scheduler: control, car state and the
// configuration register around a row of floor cells.
// Depends on edsch_pkg, edsch_req_if, edsch_rsp_if and edsch_cell.
//
// Usage: words arrive on req_chan as either a floor call (req_type 0) or a
// movement tick (req_type 1); every word yields exactly one word on rsp_chan
// with the car floor, heading, idle flag and the moved, door and reject flags.
// A floor call's result is registered at the accepting edge. A tick waits
// while a scan wave travels up the row of MAX_FLOORS floor cells, one cell
// per cycle, and its result is registered when the wave leaves the last
// cell. One word is worked on at a time.
// The result sits in an output register; req_chan.ready is high when no scan
// is running and the output register is empty or being read in that cycle.
// A stalled receiver therefore holds off the next word but loses nothing.
// The user must write num_floors through the csr_ port while the block is
// idle; the block does not enforce it. Reset clears all calls, puts the car
// at floor 1 heading up and idle, and sets num_floors to 32.
module elevator_direction_scheduler_top #(
   parameter int MAX_FLOORS = edsch_pkg::MAX_FLOORS
) (
   input  logic                             clock,
   input  logic                             reset,
   edsch_req_if.sink                        req_chan,
   edsch_rsp_if.source                      rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [edsch_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [edsch_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [edsch_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int FW    = edsch_pkg::FLOOR_W;
   localparam int CNT_W = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_FLOORS - 1);
   localparam logic [FW-1:0]    TOP_FLOOR = FW'(MAX_FLOORS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [FW-1:0]       car_ff, car_in;
   logic                heading_ff, heading_in;
   logic                idle_ff, idle_in;
   logic [FW-1:0]       num_floors_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                moved_ff, moved_in;
   logic                door_ff, door_in;
   logic                rej_ff, rej_in;

   logic                accept;
   logic                is_request;
   logic                scan_done;
   logic                csr_write;
   logic [FW-1:0]       limit;
   logic                reject;
   logic [FW-1:0]       target;
   logic                any_call;
   logic                at_target;
   edsch_pkg::scan_type scan_w [0:MAX_FLOORS];
   edsch_pkg::cmd_type  cmd;

   assign scan_w[0] = '0;

   for (genvar i = 0; i < MAX_FLOORS; i++) begin : g_cell
      edsch_cell #(
         .CELL_FLOOR(i + 1)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .scan_in (scan_w[i]),
         .scan_out(scan_w[i + 1])
      );
   end

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_request     = (req_chan.req_type == edsch_pkg::REQ_FLOOR);
   assign scan_done      = (state_ff == ST_SCAN) && (cnt_ff == SCAN_LAST);

   assign limit  = (num_floors_ff > TOP_FLOOR) ? TOP_FLOOR : num_floors_ff;
   assign reject = (req_chan.floor == '0) || (req_chan.floor > limit);

   assign any_call = (scan_w[MAX_FLOORS].low_up != '0) || (scan_w[MAX_FLOORS].high_dn != '0);

   always_comb begin
      heading_in = heading_ff;
      if (scan_done && any_call) begin
         if (heading_ff && scan_w[MAX_FLOORS].low_up == '0) begin
            heading_in = 1'b0;
         end else if (!heading_ff && scan_w[MAX_FLOORS].high_dn == '0) begin
            heading_in = 1'b1;
         end
      end
   end

   assign target    = heading_in ? scan_w[MAX_FLOORS].low_up : scan_w[MAX_FLOORS].high_dn;
   assign at_target = (car_ff == target);

   always_comb begin
      cmd.floor  = accept ? req_chan.floor : target;
      cmd.set_up = accept && is_request && !reject && req_chan.request_up;
      cmd.set_dn = accept && is_request && !reject && !req_chan.request_up;
      cmd.clr_up = scan_done && any_call && at_target && heading_in;
      cmd.clr_dn = scan_done && any_call && at_target && !heading_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      car_in       = car_ff;
      idle_in      = idle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      moved_in     = moved_ff;
      door_in      = door_ff;
      rej_in       = rej_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if (is_request) begin
                  rsp_valid_in = 1'b1;
                  moved_in     = 1'b0;
                  door_in      = 1'b0;
                  rej_in       = reject;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (scan_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rej_in       = 1'b0;
               moved_in     = 1'b0;
               door_in      = 1'b0;
               idle_in      = !any_call;
               if (any_call) begin
                  if (at_target) begin
                     door_in = 1'b1;
                  end else begin
                     moved_in = 1'b1;
                     car_in   = (target > car_ff) ? car_ff + 1'b1 : car_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         car_ff        <= FW'(1);
         heading_ff    <= 1'b1;
         idle_ff       <= 1'b1;
         num_floors_ff <= edsch_pkg::NUM_FLOORS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         car_ff       <= car_in;
         heading_ff   <= heading_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_paddr == edsch_pkg::CSR_NUM_FLOORS) begin
            num_floors_ff <= csr_pwdata[FW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      moved_ff <= moved_in;
      door_ff  <= door_in;
      rej_ff   <= rej_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.current_floor    = car_ff;
   assign rsp_chan.direction_up     = heading_ff;
   assign rsp_chan.is_idle          = idle_ff;
   assign rsp_chan.moved            = moved_ff;
   assign rsp_chan.door_opened      = door_ff;
   assign rsp_chan.request_rejected = rej_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == edsch_pkg::CSR_NUM_FLOORS)
                       ? {{(edsch_pkg::CSR_DATA_W - FW){1'b0}}, num_floors_ff}
                       : '0;

endmodule

/* rtl/edsch_checker.sv */
// Port-level checker for the elevator direction scheduler, bound to the
// top level. Depends on edsch_pkg and the top level's response channel.
module edsch_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [edsch_pkg::FLOOR_W-1:0] current_floor,
   input logic                          is_idle,
   input logic                          moved,
   input logic                          door_opened,
   input logic                          request_rejected
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result word dropped while stalled.");

   a_move_or_door: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(moved && door_opened))
      else $error("Car moved and opened its door on the same tick.");

   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (request_rejected || is_idle) |-> !moved && !door_opened)
      else $error("Rejected call or idle tick changed the car.");

   a_floor_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> current_floor != '0)
      else $error("Car reported at floor zero.");

endmodule

bind elevator_direction_scheduler_top edsch_checker u_edsch_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .current_floor   (rsp_chan.current_floor),
   .is_idle         (rsp_chan.is_idle),
   .moved           (rsp_chan.moved),
   .door_opened     (rsp_chan.door_opened),
   .request_rejected(rsp_chan.request_rejected)
);

/* sim/elevator_direction_scheduler_top_test.sv */
// Self-checking testbench for elevator_direction_scheduler_top: floor calls and
// movement ticks are predicted in the bench and every result word is compared.
// Depends on edsch_pkg, edsch_req_if, edsch_rsp_if and the scheduler RTL.
module elevator_direction_scheduler_top_test;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [edsch_pkg::FLOOR_W-1:0] current_floor;
      logic                          direction_up;
      logic                          is_idle;
      logic                          moved;
      logic                          door_opened;
      logic                          request_rejected;
   } car_status_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [edsch_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [edsch_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [edsch_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   edsch_req_if req_chan();
   edsch_rsp_if rsp_chan();

   elevator_direction_scheduler_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Bench copy of the car and its call maps; bit f-1 stands for floor f.
   logic [edsch_pkg::MAX_FLOORS-1:0] up_calls;
   logic [edsch_pkg::MAX_FLOORS-1:0] down_calls;
   int                               car_floor;
   logic                             heading_up;
   logic                             car_idle;
   int                               floor_limit;

   car_status_type status_due[$];
   int             mismatches;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             hold_left;
   int             cycle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic int lowest_call(logic [edsch_pkg::MAX_FLOORS-1:0] map);
      for (int f = 1; f <= edsch_pkg::MAX_FLOORS; f++)
         if (map[f-1]) return f;
      return 0;
   endfunction

   function automatic int highest_call(logic [edsch_pkg::MAX_FLOORS-1:0] map);
      for (int f = edsch_pkg::MAX_FLOORS; f >= 1; f--)
         if (map[f-1]) return f;
      return 0;
   endfunction

   task automatic advance_car(logic kind, logic [edsch_pkg::FLOOR_W-1:0] fl, logic up);
      car_status_type s;
      int             eff;
      int             target;
      s = '0;
      if (kind == edsch_pkg::REQ_FLOOR) begin
         eff = (floor_limit > edsch_pkg::MAX_FLOORS) ? edsch_pkg::MAX_FLOORS : floor_limit;
         if (int'(fl) < 1 || int'(fl) > eff) begin
            s.request_rejected = 1'b1;
         end else if (up) begin
            up_calls[int'(fl) - 1] = 1'b1;
         end else begin
            down_calls[int'(fl) - 1] = 1'b1;
         end
      end else if (up_calls == '0 && down_calls == '0) begin
         car_idle = 1'b1;
      end else begin
         car_idle = 1'b0;
         if (heading_up && up_calls == '0) heading_up = 1'b0;
         else if (!heading_up && down_calls == '0) heading_up = 1'b1;
         target = heading_up ? lowest_call(up_calls) : highest_call(down_calls);
         if (target == car_floor) begin
            s.door_opened = 1'b1;
            if (heading_up) up_calls[target-1] = 1'b0;
            else down_calls[target-1] = 1'b0;
         end else if (target > car_floor) begin
            car_floor++;
            s.moved = 1'b1;
         end else begin
            car_floor--;
            s.moved = 1'b1;
         end
      end
      s.current_floor = car_floor[edsch_pkg::FLOOR_W-1:0];
      s.direction_up  = heading_up;
      s.is_idle       = car_idle;
      status_due = {status_due, s};
   endtask

   task automatic send_word(logic kind, logic [edsch_pkg::FLOOR_W-1:0] fl, logic up);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.req_type   = kind;
      req_chan.floor      = fl;
      req_chan.request_up = up;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      advance_car(kind, fl, up);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (status_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_floor_limit(logic [edsch_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = edsch_pkg::CSR_NUM_FLOORS;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      floor_limit = int'(value[edsch_pkg::FLOOR_W-1:0]);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   initial begin : check_results
      car_status_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (status_due.size() == 0) begin
               $error("result word arrived with none expected");
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("current_floor", want.current_floor, rsp_chan.current_floor);
               check_field("direction_up", want.direction_up, rsp_chan.direction_up);
               check_field("is_idle", want.is_idle, rsp_chan.is_idle);
               check_field("moved", want.moved, rsp_chan.moved);
               check_field("door_opened", want.door_opened, rsp_chan.door_opened);
               check_field("request_rejected", want.request_rejected,
                           rsp_chan.request_rejected);
            end
         end
      end
   end

   initial begin : drive_receiver
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic test_idle_tick();
      send_word(edsch_pkg::REQ_TICK, 6'd0, 1'b0);
      send_word(edsch_pkg::REQ_TICK, 6'd63, 1'b1);
      wait_for_results();
   endtask

   task automatic test_floor_calls();
      send_word(edsch_pkg::REQ_FLOOR, 6'd5, 1'b1);
      send_word(edsch_pkg::REQ_FLOOR, 6'd5, 1'b1);
      send_word(edsch_pkg::REQ_FLOOR, 6'd3, 1'b0);
      send_word(edsch_pkg::REQ_FLOOR, 6'd0, 1'b1);
      send_word(edsch_pkg::REQ_FLOOR, 6'd63, 1'b0);
      send_word(edsch_pkg::REQ_FLOOR, 6'd33, 1'b1);
      send_word(edsch_pkg::REQ_FLOOR, 6'd32, 1'b1);
      send_word(edsch_pkg::REQ_FLOOR, 6'd1, 1'b0);
      wait_for_results();
   endtask

   task automatic test_scan_ticks();
      repeat (6) send_word(edsch_pkg::REQ_TICK, 6'($urandom_range(63)),
                           1'($urandom_range(1)));
      wait_for_results();
   endtask

   task automatic test_floor_limits();
      write_floor_limit(32'd0);
      send_word(edsch_pkg::REQ_FLOOR, 6'd1, 1'b1);
      wait_for_results();
      write_floor_limit(32'd63);
      send_word(edsch_pkg::REQ_FLOOR, 6'd32, 1'b0);
      send_word(edsch_pkg::REQ_FLOOR, 6'd33, 1'b0);
      wait_for_results();
      write_floor_limit(32'd2);
      send_word(edsch_pkg::REQ_FLOOR, 6'd3, 1'b1);
      send_word(edsch_pkg::REQ_FLOOR, 6'd2, 1'b0);
      repeat (3) send_word(edsch_pkg::REQ_TICK, 6'd0, 1'b0);
      wait_for_results();
   endtask

   task automatic random_phase(int count, int idle_pct, int stall_pct);
      logic                          kind;
      logic [edsch_pkg::FLOOR_W-1:0] fl;
      int                            eff;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         eff = (floor_limit > edsch_pkg::MAX_FLOORS) ? edsch_pkg::MAX_FLOORS : floor_limit;
         kind = ($urandom_range(1) == 1) ? edsch_pkg::REQ_TICK : edsch_pkg::REQ_FLOOR;
         if (kind == edsch_pkg::REQ_FLOOR && eff > 0 && $urandom_range(99) < 80)
            fl = 6'($urandom_range(eff, 1));
         else
            fl = 6'($urandom_range(63));
         send_word(kind, fl, 1'($urandom_range(1)));
      end
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      write_floor_limit(32'd32);
      random_phase(320, 0, 0);
      write_floor_limit(32'd1);
      random_phase(310, 88, 0);
      write_floor_limit({26'($urandom()), 6'($urandom_range(31, 2))});
      random_phase(310, 0, 88);
      write_floor_limit(32'd63);
      random_phase(310, 35, 35);
   endtask

   task automatic test_backpressure();
      write_floor_limit(32'd32);
      hold_left = 400;
      random_phase(30, 0, 0);
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.req_type   = edsch_pkg::REQ_FLOOR;
      req_chan.floor      = '0;
      req_chan.request_up = 1'b0;
      rsp_chan.ready   = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = edsch_pkg::CSR_NUM_FLOORS;
      csr_pwdata       = '0;
      up_calls         = '0;
      down_calls       = '0;
      car_floor        = 1;
      heading_up       = 1'b1;
      car_idle         = 1'b1;
      floor_limit      = int'(edsch_pkg::NUM_FLOORS_RESET);
      mismatches       = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_left        = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_tick();
      test_floor_calls();
      test_scan_ticks();
      test_floor_limits();
      test_random_traffic();
      test_backpressure();

      repeat (edsch_pkg::MAX_FLOORS + 8) @(posedge clock);
      if (status_due.size() != 0) begin
         $error("%0d result words never arrived", status_due.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
rtl/edsch_pkg.sv
rtl/edsch_if.sv
rtl/edsch_cell.sv
rtl/elevator_direction_scheduler_top.sv
rtl/edsch_checker.sv
sim/elevator_direction_scheduler_top_test.sv
